// ===== design/alsnap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package alsnap_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_X      = 3'd0,
    REG_VIEW_Y      = 3'd1,
    REG_VIEW_WIDTH  = 3'd2,
    REG_VIEW_HEIGHT = 3'd3,
    REG_FB_WIDTH    = 3'd4,
    REG_FB_HEIGHT   = 3'd5
  } alsnap_reg_e;

  typedef struct packed {
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    logic [15:0]        line_thickness;
  } alsnap_in_t;

  typedef struct packed {
    logic signed [31:0] rect_x;
    logic signed [31:0] rect_y;
    logic [30:0]        rect_w;
    logic [30:0]        rect_h;
    logic               drawn;
  } alsnap_out_t;

  typedef struct packed {
    logic signed [31:0] view_x;
    logic signed [31:0] view_y;
    logic signed [31:0] view_width;
    logic signed [31:0] view_height;
    logic [14:0]        fb_width;
    logic [14:0]        fb_height;
  } alsnap_cfg_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic        drawn;
    logic        vert;
    logic [31:0] origin;
    logic [30:0] ext;
    logic [14:0] pix;
    logic [31:0] other;
    logic [30:0] len;
    logic [48:0] prod;   // (p - origin) * pix
    logic [39:0] pe;     // pixels * extent
  } alsnap_cmd_t;

endpackage

`default_nettype wire

// ===== design/axis_line_pixel_snap_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Snaps an axis-aligned line segment to whole pixels and returns a world
// rectangle, one result word for every input word. A new word is accepted every
// clock cycle while in_stall_o is low; a word's result passes through the front
// register, the queue, then two bit-per-stage pipelined dividers of 51 and 53
// stages plus the rescale and output stages. The front and back halves are
// joined by a four-entry queue, so input stalls only when that queue and the
// front register are full. Coordinates are Q16.16; configuration may be
// written only while the block is empty.
module axis_line_pixel_snap_core
  import alsnap_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire alsnap_in_t            in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output alsnap_out_t                out_data_o
);

  alsnap_cfg_t cfg_q;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.view_x      <= '0;
      cfg_q.view_y      <= '0;
      cfg_q.view_width  <= 32'sd65536;
      cfg_q.view_height <= 32'sd65536;
      cfg_q.fb_width    <= 15'd1;
      cfg_q.fb_height   <= 15'd1;
    end else if (cfg_we_i) begin
      unique case (alsnap_reg_e'(cfg_idx_i))
        REG_VIEW_X:      cfg_q.view_x      <= cfg_wdata_i;
        REG_VIEW_Y:      cfg_q.view_y      <= cfg_wdata_i;
        REG_VIEW_WIDTH:  cfg_q.view_width  <= cfg_wdata_i;
        REG_VIEW_HEIGHT: cfg_q.view_height <= cfg_wdata_i;
        REG_FB_WIDTH:    cfg_q.fb_width    <= cfg_wdata_i[14:0];
        REG_FB_HEIGHT:   cfg_q.fb_height   <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  logic        full, empty, push, pop;
  alsnap_cmd_t cmd_in, cmd_out;

  alsnap_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_valid_i, .in_stall_o, .in_data_i,
    .full_i(full), .push_o(push), .cmd_o(cmd_in)
  );

  alsnap_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(cmd_in), .full_o(full),
    .pop_i(pop), .data_o(cmd_out), .empty_o(empty)
  );

  alsnap_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cmd_i(cmd_out), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

`default_nettype wire

// ===== design/alsnap_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage, NW stages.
module alsnap_div #(
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [NW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  logic          v_q [NW];
  logic [DW-1:0] r_q [NW];
  logic [NW-1:0] n_q [NW];
  logic [NW-1:0] q_q [NW];
  logic [DW-1:0] d_q [NW];
  logic [SW-1:0] s_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [NW-1:0] n_in;
    logic [NW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = '0;
      assign n_in = num_i;
      assign q_in = '0;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
      assign n_in = n_q[k-1];
      assign q_in = q_q[k-1];
      assign d_in = d_q[k-1];
      assign s_in = s_q[k-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign trial = {r_in, n_in[NW-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
        n_q[k] <= n_in << 1;
        q_q[k] <= {q_in[NW-2:0], ge};
        d_q[k] <= d_in;
        s_q[k] <= s_in;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = q_q[NW-1];
  assign side_o  = s_q[NW-1];

endmodule

`default_nettype wire

// ===== design/alsnap_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Accept a segment, classify it and form the first products.
module alsnap_front
  import alsnap_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire alsnap_cfg_t cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire alsnap_in_t  in_data_i,
  input  wire logic        full_i,
  output logic             push_o,
  output alsnap_cmd_t      cmd_o
);

  logic        f1_v_q;
  alsnap_cmd_t cmd_q, cmd_d;

  logic        vert, horiz, view_ok;
  logic [16:0] th_sum;
  logic [8:0]  px;
  logic [31:0] p, org, a, b;
  logic [32:0] diff, dab, mag;
  logic signed [48:0] diff_x, pix_x;

  always_comb begin
    vert    = in_data_i.from_x == in_data_i.to_x;
    horiz   = in_data_i.from_y == in_data_i.to_y;
    view_ok = !cfg_i.view_width[31] && (cfg_i.view_width != '0) &&
              !cfg_i.view_height[31] && (cfg_i.view_height != '0) &&
              (cfg_i.fb_width != '0) && (cfg_i.fb_height != '0);

    // round thickness half up, at least one pixel
    th_sum = {1'b0, in_data_i.line_thickness} + 17'd128;
    px     = (th_sum[16:8] == '0) ? 9'd1 : th_sum[16:8];

    // pick the snapped axis
    p   = vert ? in_data_i.from_x : in_data_i.from_y;
    org = vert ? cfg_i.view_x : cfg_i.view_y;
    a   = vert ? in_data_i.from_y : in_data_i.from_x;
    b   = vert ? in_data_i.to_y : in_data_i.to_x;

    cmd_d.drawn = view_ok && (in_data_i.line_thickness != '0) &&
                  (vert ? !horiz : horiz);
    cmd_d.vert  = vert;
    cmd_d.origin = org;
    cmd_d.ext   = vert ? cfg_i.view_width[30:0] : cfg_i.view_height[30:0];
    cmd_d.pix   = vert ? cfg_i.fb_width : cfg_i.fb_height;

    // other edge and saturated length
    cmd_d.other = ($signed(a) < $signed(b)) ? a : b;
    dab = {a[31], a} - {b[31], b};
    mag = dab[32] ? 33'(-dab) : dab;
    cmd_d.len = (mag[32:31] != '0) ? '1 : mag[30:0];

    diff   = {p[31], p} - {org[31], org};
    diff_x = {{16{diff[32]}}, diff};
    pix_x  = {34'd0, cmd_d.pix};
    cmd_d.prod = 49'(diff_x * pix_x);
    cmd_d.pe   = 40'(px) * 40'(cmd_d.ext);
  end

  assign in_stall_o = f1_v_q && full_i;
  assign push_o     = f1_v_q && !full_i;
  assign cmd_o      = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      f1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/alsnap_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Short command queue between front and back.
module alsnap_fifo
  import alsnap_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire alsnap_cmd_t data_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output alsnap_cmd_t      data_o,
  output logic             empty_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  alsnap_cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/alsnap_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Carry out the snap: divide, rescale, divide again, saturate.
module alsnap_back
  import alsnap_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        empty_i,
  input  wire alsnap_cmd_t cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output alsnap_out_t      out_data_o
);

  localparam int N1W = 51;
  localparam int N2W = 53;

  typedef struct packed {
    logic        neg;
    logic        drawn;
    logic        vert;
    logic [31:0] origin;
    logic [30:0] ext;
    logic [14:0] pix;
    logic [31:0] other;
    logic [30:0] len;
  } side1_t;

  typedef struct packed {
    logic        neg;
    logic        drawn;
    logic        vert;
    logic [31:0] origin;
    logic [31:0] other;
    logic [30:0] len;
    logic [30:0] band;
  } side2_t;

  logic en;
  assign en    = !out_valid_o || !out_stall_i;
  assign pop_o = en && !empty_i;

  // start numerator and band dividend
  logic [50:0]    num, mag;
  logic           b0_v_q;
  side1_t         b0_s_q;
  logic [N1W-1:0] n1_q, n3_q;
  logic [31:0]    d1_q;
  logic [15:0]    d3_q;

  always_comb begin
    num = {cmd_i.prod[48], cmd_i.prod, 1'b0} - {11'd0, cmd_i.pe};
    mag = num[50] ? 51'(-num) : num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q <= 1'b0;
    end else if (en) begin
      b0_v_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_s_q <= '{neg: num[50], drawn: cmd_i.drawn, vert: cmd_i.vert,
                  origin: cmd_i.origin, ext: cmd_i.ext, pix: cmd_i.pix,
                  other: cmd_i.other, len: cmd_i.len};
      n1_q <= mag + {20'd0, cmd_i.ext};
      d1_q <= {cmd_i.ext, 1'b0};
      n3_q <= N1W'({cmd_i.pe, 1'b0} + {26'd0, cmd_i.pix});
      d3_q <= {cmd_i.pix, 1'b0};
    end
  end

  // start pixel and band size in parallel
  logic           d1_v;
  logic [N1W-1:0] q1, q3;
  side1_t         d1_s;

  alsnap_div #(.NW(N1W), .DW(32), .SW($bits(side1_t))) u_div_start (
    .clk_i, .rst_ni, .en_i(en), .valid_i(b0_v_q), .num_i(n1_q), .den_i(d1_q),
    .side_i(b0_s_q), .valid_o(d1_v), .quo_o(q1), .side_o(d1_s)
  );

  alsnap_div #(.NW(N1W), .DW(16), .SW(1)) u_div_band (
    .clk_i, .rst_ni, .en_i(en), .valid_i(b0_v_q), .num_i(n3_q), .den_i(d3_q),
    .side_i(1'b0), .valid_o(), .quo_o(q3), .side_o()
  );

  // scale start back to world units: two partial products
  logic        m1_v_q, m2_v_q;
  side1_t      m1_s_q;
  logic [56:0] lo_q;
  logic [55:0] hi_q;
  logic [30:0] band_q;
  side2_t      m2_s_q;
  logic [N2W-1:0] n2_q;
  logic [15:0] d2_q;
  logic [N2W-1:0] m_sum;

  assign m_sum = N2W'(lo_q) + {hi_q[26:0], 26'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= d1_v;
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_s_q <= d1_s;
      lo_q   <= 57'(q1[25:0]) * 57'(d1_s.ext);
      hi_q   <= 56'(q1[50:26]) * 56'(d1_s.ext);
      band_q <= (q3[50:31] != '0) ? '1 : q3[30:0];
      m2_s_q <= '{neg: m1_s_q.neg, drawn: m1_s_q.drawn, vert: m1_s_q.vert,
                  origin: m1_s_q.origin, other: m1_s_q.other, len: m1_s_q.len,
                  band: band_q};
      n2_q   <= {m_sum[51:0], 1'b0} + {37'd0, m1_s_q.pix};
      d2_q   <= {m1_s_q.pix, 1'b0};
    end
  end

  logic           d2_v;
  logic [N2W-1:0] q2;
  side2_t         d2_s;

  alsnap_div #(.NW(N2W), .DW(16), .SW($bits(side2_t))) u_div_world (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m2_v_q), .num_i(n2_q), .den_i(d2_q),
    .side_i(m2_s_q), .valid_o(d2_v), .quo_o(q2), .side_o(d2_s)
  );

  // add origin, saturate, assemble the word
  logic [54:0] world, edge_sum;
  logic [31:0] snap;
  alsnap_out_t res;

  always_comb begin
    world    = d2_s.neg ? 55'(-{2'b00, q2}) : {2'b00, q2};
    edge_sum = {{23{d2_s.origin[31]}}, d2_s.origin} + world;
    if ((&edge_sum[54:31]) || !(|edge_sum[54:31])) begin
      snap = edge_sum[31:0];
    end else if (edge_sum[54]) begin
      snap = 32'h8000_0000;
    end else begin
      snap = 32'h7FFF_FFFF;
    end
    res = '0;
    if (d2_s.drawn) begin
      res.drawn  = 1'b1;
      res.rect_x = d2_s.vert ? snap : d2_s.other;
      res.rect_y = d2_s.vert ? d2_s.other : snap;
      res.rect_w = d2_s.vert ? d2_s.band : d2_s.len;
      res.rect_h = d2_s.vert ? d2_s.len : d2_s.band;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o <= res;
    end
  end

endmodule

`default_nettype wire
